FILE: sv/kidv_pkg.sv
// ----------------------------------------------------------------------------
// kidv_pkg: shared types and constants for the inverse-distance vote block
// Field widths, command and register codes, fixed-point constants and the
// sequencer state type.
// ----------------------------------------------------------------------------
package kidv_pkg;

   // field widths
   localparam int TAG_W   = 10;
   localparam int FIDX_W  = 4;
   localparam int FEAT_W  = 16;
   localparam int TOTAL_W = 35;
   localparam int FCNT_W  = 5;
   localparam int TCNT_W  = 11;
   localparam int POW_W   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 48;

   // arithmetic widths
   localparam int SQ_W    = 32;   // one squared difference, Q.16
   localparam int SUM_W   = 37;   // sum of up to 31 squares
   localparam int ACC_W   = 48;   // power accumulator, Q32.16
   localparam int CHUNK_W = 13;   // multiplier slice of the sum
   localparam int MUL_W   = ACC_W + CHUNK_W;
   localparam int PROD_W  = 86;   // full product plus rounding headroom
   localparam int DEN_W   = 49;
   localparam int QUO_W   = 25;

   // commands
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TEST = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FEATURE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TRAIN_COUNT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_POWER         = 2'd2;

   // register reset values
   localparam logic [FCNT_W-1:0] FCNT_RESET = 5'd1;
   localparam logic [TCNT_W-1:0] TCNT_RESET = 11'd0;
   localparam logic [POW_W-1:0]  POW_RESET  = 3'd4;

   // fixed-point constants
   localparam logic [ACC_W-1:0]   ONE_Q16   = 48'h0000_0001_0000;
   localparam logic [ACC_W-1:0]   DPOW_MAX  = 48'hFFFF_FFFF_FFFF;
   localparam logic [PROD_W-1:0]  ROUND_HALF = 86'h8000;
   localparam logic [DEN_W-1:0]   NUM_ONE   = 49'h100_0000_0000;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = 35'h7_FFFF_FFFF;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SQUARE,
      ST_POW,
      ST_DIV_LOAD,
      ST_DIV,
      ST_ACCUM,
      ST_FINISH
   } state_type;

endpackage

FILE: sv/knn_inverse_distance_vote.sv
// Walk: a completing test beat starts a walk over the nt training points (nf features
//   each): read and square every feature, raise the sum to the power in three-slice
//   multiplier steps, divide, accumulate; ST_FINISH then hands the result over.
// Throughput: load beats and non-final test beats take one cycle each; the
//   walk holds req_tready low; one shared multiplier and a one-bit divider set the rate.
// Reset: synchronous, active high; no clearing pass, stores undefined until written.
// ----------------------------------------------------------------------------
// knn_inverse_distance_vote: inverse-distance weighted vote
// Stores a training set, then sums 1/(1+S^p) over all training points for
// each completed test point, S being the squared Euclidean distance.
// ----------------------------------------------------------------------------
module knn_inverse_distance_vote #(
   parameter int MAX_TRAIN    = 1024,
   parameter int MAX_FEATURES = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // point_index[9:0], feature_index[13:10], value[29:14]
   input  logic        req_tuser,  // cmd
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // test_tag[9:0], vote_total[44:10]
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_data
);

   localparam int DEPTH   = MAX_TRAIN * MAX_FEATURES;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int TADDR_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int NF_W    = $clog2(MAX_FEATURES + 1);
   localparam int K_W     = $clog2(MAX_TRAIN + 1);

   // configuration registers
   logic [kidv_pkg::FCNT_W-1:0] feature_count_ff;
   logic [kidv_pkg::TCNT_W-1:0] train_count_ff;
   logic [kidv_pkg::POW_W-1:0]  power_ff;

   // sequencer registers
   kidv_pkg::state_type state_ff, state_in;
   logic [NF_W-1:0]  f_ff, f_in;
   logic [K_W-1:0]   k_ff, k_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [kidv_pkg::SUM_W-1:0]   s_ff, s_in;
   logic [kidv_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic [kidv_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [kidv_pkg::POW_W-1:0]   pcnt_ff, pcnt_in;
   logic [1:0]                   j_ff, j_in;
   logic [kidv_pkg::DEN_W-1:0]   den_ff, den_in;
   logic [kidv_pkg::DEN_W-1:0]   rem_ff, rem_in;
   logic [kidv_pkg::QUO_W-1:0]   num_lo_ff, num_lo_in;
   logic [kidv_pkg::QUO_W-1:0]   q_ff, q_in;
   logic [4:0]                   div_cnt_ff, div_cnt_in;
   logic [kidv_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic [kidv_pkg::TAG_W-1:0]   tag_ff, tag_in;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [kidv_pkg::TAG_W-1:0]   rsp_tag_ff, rsp_tag_in;
   logic [kidv_pkg::TOTAL_W-1:0] rsp_total_ff, rsp_total_in;

   // request fields
   logic                         req_cmd;
   logic [kidv_pkg::TAG_W-1:0]   req_point;
   logic [kidv_pkg::FIDX_W-1:0]  req_fidx;
   logic [kidv_pkg::FEAT_W-1:0]  req_value;
   logic                         req_accept;

   // effective counts
   logic [NF_W-1:0] nf;
   logic [K_W-1:0]  nt;

   // store ports
   logic              train_we, test_we;
   logic [ADDR_W-1:0] train_waddr, train_raddr;
   logic [kidv_pkg::FEAT_W-1:0] train_rdata, test_rdata;

   // datapath
   logic signed [16:0]           diff;
   logic signed [33:0]           diff_sq;
   logic [kidv_pkg::CHUNK_W-1:0] chunk;
   logic [kidv_pkg::MUL_W-1:0]   mul;
   logic [kidv_pkg::PROD_W-1:0]  mul_sh;
   logic [kidv_pkg::PROD_W-1:0]  prod_rnd;
   logic [kidv_pkg::DEN_W-1:0]   den_new, num_new;
   logic [kidv_pkg::DEN_W:0]     div_t;
   logic                         div_ge;
   logic [kidv_pkg::TOTAL_W:0]   total_sum;

   assign req_cmd    = req_tuser;
   assign req_point  = req_tdata[9:0];
   assign req_fidx   = req_tdata[13:10];
   assign req_value  = req_tdata[29:14];
   assign req_tready = (state_ff == kidv_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_total_ff, rsp_tag_ff};

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         feature_count_ff <= kidv_pkg::FCNT_RESET;
         train_count_ff   <= kidv_pkg::TCNT_RESET;
         power_ff         <= kidv_pkg::POW_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            kidv_pkg::REG_FEATURE_COUNT: feature_count_ff <= csr_data[4:0];
            kidv_pkg::REG_TRAIN_COUNT:   train_count_ff   <= csr_data;
            kidv_pkg::REG_POWER:         power_ff         <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // clamp counts to what the stores hold
   always_comb begin
      if (feature_count_ff == '0) begin
         nf = NF_W'(1);
      end else if (32'(feature_count_ff) > MAX_FEATURES) begin
         nf = NF_W'(MAX_FEATURES);
      end else begin
         nf = NF_W'(feature_count_ff);
      end
      if (32'(train_count_ff) > MAX_TRAIN) begin
         nt = K_W'(MAX_TRAIN);
      end else begin
         nt = K_W'(train_count_ff);
      end
   end

   // store writes
   assign train_we    = req_accept && (req_cmd == kidv_pkg::CMD_LOAD) &&
                        (32'(req_fidx) < 32'(nf)) && (32'(req_point) < MAX_TRAIN);
   assign test_we     = req_accept && (req_cmd == kidv_pkg::CMD_TEST) &&
                        (32'(req_fidx) < 32'(nf));
   assign train_waddr = ADDR_W'(32'(req_point) * MAX_FEATURES + 32'(req_fidx));
   assign train_raddr = base_ff + ADDR_W'(f_ff);

   kidv_ram #(
      .WIDTH (kidv_pkg::FEAT_W),
      .DEPTH (DEPTH)
   ) u_train_ram (
      .clock (clock),
      .we    (train_we),
      .waddr (train_waddr),
      .wdata (req_value),
      .raddr (train_raddr),
      .rdata (train_rdata)
   );

   kidv_ram #(
      .WIDTH (kidv_pkg::FEAT_W),
      .DEPTH (MAX_FEATURES)
   ) u_test_ram (
      .clock (clock),
      .we    (test_we),
      .waddr (TADDR_W'(req_fidx)),
      .wdata (req_value),
      .raddr (f_ff[TADDR_W-1:0]),
      .rdata (test_rdata)
   );

   // squared difference of one feature
   assign diff    = $signed({test_rdata[15], test_rdata}) -
                    $signed({train_rdata[15], train_rdata});
   assign diff_sq = diff * diff;

   // shared multiplier: accumulator times one slice of the sum
   always_comb begin
      case (j_ff)
         2'd0:    chunk = s_ff[12:0];
         2'd1:    chunk = s_ff[25:13];
         default: chunk = {2'b00, s_ff[36:26]};
      endcase
   end
   assign mul = kidv_pkg::MUL_W'(acc_ff) * kidv_pkg::MUL_W'(chunk);
   always_comb begin
      case (j_ff)
         2'd0:    mul_sh = kidv_pkg::PROD_W'(mul);
         2'd1:    mul_sh = kidv_pkg::PROD_W'(mul) << kidv_pkg::CHUNK_W;
         default: mul_sh = kidv_pkg::PROD_W'(mul) << (2 * kidv_pkg::CHUNK_W);
      endcase
   end
   assign prod_rnd = prod_ff + kidv_pkg::ROUND_HALF;

   // divider operands and one restoring step
   assign den_new   = kidv_pkg::DEN_W'(acc_ff) + kidv_pkg::DEN_W'(kidv_pkg::ONE_Q16);
   assign num_new   = kidv_pkg::NUM_ONE + (den_new >> 1);
   assign div_t     = {rem_ff, num_lo_ff[kidv_pkg::QUO_W-1]};
   assign div_ge    = div_t >= {1'b0, den_ff};
   assign total_sum = {1'b0, total_ff} + (kidv_pkg::TOTAL_W + 1)'(q_ff);

   // sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kidv_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      f_ff         <= f_in;
      k_ff         <= k_in;
      base_ff      <= base_in;
      s_ff         <= s_in;
      acc_ff       <= acc_in;
      prod_ff      <= prod_in;
      pcnt_ff      <= pcnt_in;
      j_ff         <= j_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      num_lo_ff    <= num_lo_in;
      q_ff         <= q_in;
      div_cnt_ff   <= div_cnt_in;
      total_ff     <= total_in;
      tag_ff       <= tag_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_total_ff <= rsp_total_in;
   end

   // next state and datapath control
   always_comb begin
      state_in     = state_ff;
      f_in         = f_ff;
      k_in         = k_ff;
      base_in      = base_ff;
      s_in         = s_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      pcnt_in      = pcnt_ff;
      j_in         = j_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      num_lo_in    = num_lo_ff;
      q_in         = q_ff;
      div_cnt_in   = div_cnt_ff;
      total_in     = total_ff;
      tag_in       = tag_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_total_in = rsp_total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         kidv_pkg::ST_IDLE: begin
            // last test feature starts the walk
            if (test_we && (32'(req_fidx) + 1 == 32'(nf))) begin
               tag_in   = req_point;
               total_in = '0;
               f_in     = '0;
               k_in     = '0;
               base_in  = '0;
               s_in     = '0;
               if (nt == '0) begin
                  state_in = kidv_pkg::ST_FINISH;
               end else begin
                  state_in = kidv_pkg::ST_READ;
               end
            end
         end
         kidv_pkg::ST_READ: begin
            state_in = kidv_pkg::ST_SQUARE;
         end
         kidv_pkg::ST_SQUARE: begin
            s_in = s_ff + kidv_pkg::SUM_W'(diff_sq[kidv_pkg::SQ_W-1:0]);
            if (f_ff + NF_W'(1) == nf) begin
               f_in    = '0;
               acc_in  = kidv_pkg::ONE_Q16;
               pcnt_in = '0;
               j_in    = '0;
               if (power_ff == '0) begin
                  state_in = kidv_pkg::ST_DIV_LOAD;
               end else begin
                  state_in = kidv_pkg::ST_POW;
               end
            end else begin
               f_in     = f_ff + NF_W'(1);
               state_in = kidv_pkg::ST_READ;
            end
         end
         kidv_pkg::ST_POW: begin
            // three slices, then round and saturate
            if (j_ff == 2'd0) begin
               prod_in = mul_sh;
               j_in    = j_ff + 2'd1;
            end else if (j_ff != 2'd3) begin
               prod_in = prod_ff + mul_sh;
               j_in    = j_ff + 2'd1;
            end else begin
               if (prod_rnd[kidv_pkg::PROD_W-1:64] != '0) begin
                  acc_in = kidv_pkg::DPOW_MAX;
               end else begin
                  acc_in = prod_rnd[63:16];
               end
               j_in    = '0;
               pcnt_in = pcnt_ff + 3'd1;
               if (pcnt_ff + 3'd1 == power_ff) begin
                  state_in = kidv_pkg::ST_DIV_LOAD;
               end
            end
         end
         kidv_pkg::ST_DIV_LOAD: begin
            den_in     = den_new;
            rem_in     = kidv_pkg::DEN_W'(num_new[kidv_pkg::DEN_W-1:kidv_pkg::QUO_W]);
            num_lo_in  = num_new[kidv_pkg::QUO_W-1:0];
            q_in       = '0;
            div_cnt_in = '0;
            state_in   = kidv_pkg::ST_DIV;
         end
         kidv_pkg::ST_DIV: begin
            // one quotient bit per beat of the divider
            if (div_ge) begin
               rem_in = kidv_pkg::DEN_W'(div_t - {1'b0, den_ff});
            end else begin
               rem_in = kidv_pkg::DEN_W'(div_t);
            end
            q_in       = {q_ff[kidv_pkg::QUO_W-2:0], div_ge};
            num_lo_in  = num_lo_ff << 1;
            div_cnt_in = div_cnt_ff + 5'd1;
            if (div_cnt_ff == 5'(kidv_pkg::QUO_W - 1)) begin
               state_in = kidv_pkg::ST_ACCUM;
            end
         end
         kidv_pkg::ST_ACCUM: begin
            if (total_sum[kidv_pkg::TOTAL_W]) begin
               total_in = kidv_pkg::TOTAL_MAX;
            end else begin
               total_in = total_sum[kidv_pkg::TOTAL_W-1:0];
            end
            s_in = '0;
            if (k_ff + K_W'(1) == nt) begin
               state_in = kidv_pkg::ST_FINISH;
            end else begin
               k_in     = k_ff + K_W'(1);
               base_in  = base_ff + ADDR_W'(MAX_FEATURES);
               state_in = kidv_pkg::ST_READ;
            end
         end
         kidv_pkg::ST_FINISH: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_tag_in   = tag_ff;
               rsp_total_in = total_ff;
               state_in     = kidv_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kidv_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: sv/kidv_ram.sv
// ----------------------------------------------------------------------------
// kidv_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kidv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata <= mem_ff[raddr];
   end

endmodule

FILE: sv/kidv_checker.sv
// ----------------------------------------------------------------------------
// kidv_checker: port-level checks for the inverse-distance vote block
// Watches the request and result channels over time.
// ----------------------------------------------------------------------------
module kidv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // reset empties the output register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a result only appears at the end of a walk, when requests are held off
   a_rsp_after_walk: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without a walk");

   // a training load never produces a result
   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == kidv_pkg::CMD_LOAD) && !rsp_tvalid
      |=> !rsp_tvalid)
      else $error("result after a training load");

endmodule

bind knn_inverse_distance_vote kidv_checker u_kidv_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
